// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Check a condition held in the cycle after a trigger
`define ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("assertion failed");

`endif

// ===== rtl/knn_pkg.sv =====
`default_nettype none
package knn_pkg;
    localparam int TEMPLATE_COUNT = 32;
    localparam int GATE_COUNT     = 16;
    localparam int CLASS_COUNT    = 8;
    localparam int NEIGHBOR_COUNT = 5;

    localparam int TIDX_W  = $clog2(TEMPLATE_COUNT);
    localparam int GIDX_W  = $clog2(GATE_COUNT);
    localparam int CLASS_W = 3;
    localparam int SAMPLE_W = 16;
    localparam int SUM_W   = 35;
    localparam int VOTE_W  = 3;
    localparam int PICKS   = (NEIGHBOR_COUNT > TEMPLATE_COUNT) ? TEMPLATE_COUNT
                                                              : NEIGHBOR_COUNT;

    localparam logic [SAMPLE_W-1:0] SAMPLE_ONE = 16'h8000;
    localparam logic [SUM_W-1:0]    SUM_MAX    = {SUM_W{1'b1}};

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic [TIDX_W-1:0] idx;
        logic [SUM_W-1:0]  sum;
        logic [CLASS_W-1:0] label;
    } t_token;

    typedef struct packed {
        logic              req_type;
        logic [4:0]        template_index;
        logic [3:0]        gate_index;
        logic [SAMPLE_W-1:0] sample_value;
        logic [CLASS_W-1:0] class_label;
        logic              last_gate;
    } t_in_req;

    typedef struct packed {
        logic [CLASS_W-1:0] winner_class;
        logic [VOTE_W-1:0]  vote_count;
    } t_out_req;

    // Strict ordering: smaller sum, then lower index
    function automatic logic tok_less(t_token a, t_token b);
        return (a.sum < b.sum) || ((a.sum == b.sum) && (a.idx < b.idx));
    endfunction
endpackage
`default_nettype wire

// ===== rtl/knn_if.sv =====
`default_nettype none
interface knn_in_if;
    import knn_pkg::*;
    logic    valid;
    logic    ready;
    t_in_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface knn_out_if;
    import knn_pkg::*;
    logic     valid;
    logic     ready;
    t_out_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/knn_cell.sv =====
`default_nettype none
// One slot of the sorted neighbor chain: keep the better token, pass the other on
module knn_cell (
    input  wire logic            i_clk,
    input  wire logic            i_clear,
    input  wire logic            i_shift,
    input  wire logic            i_valid,
    input  wire knn_pkg::t_token i_tok,
    output logic                 o_valid,
    output knn_pkg::t_token      o_tok,
    output logic                 o_held_valid,
    output knn_pkg::t_token      o_held
);
    import knn_pkg::*;

    logic   r_held_valid;
    t_token r_held;
    logic   r_out_valid;
    t_token r_out;
    logic   keep_new;

    assign keep_new = i_valid && (!r_held_valid || tok_less(i_tok, r_held));

    // Insert the incoming token if it beats the held one; forward the loser
    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_held_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else if (i_shift) begin
            if (keep_new) begin
                r_held_valid <= 1'b1;
                r_held       <= i_tok;
                r_out_valid  <= r_held_valid;
                r_out        <= r_held;
            end else begin
                r_out_valid <= i_valid;
                r_out       <= i_tok;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_tok        = r_out;
    assign o_held_valid = r_held_valid;
    assign o_held       = r_held;
endmodule
`default_nettype wire

// ===== rtl/knn_template_classifier.sv =====
`default_nettype none
// k-nearest-neighbor classifier over 32 stored templates of 16 gates each.
// A load request stores one template sample and label in the cycle it is
// accepted, so loads can follow back to back. A query request walks the shared
// squared-difference unit over all 32 template sums, one template per cycle;
// the next request is taken once the walk is done. The request marked last
// then streams the 32 sums through a row of 5 sorting cells, drains the row,
// counts votes over 8 classes and posts the result; the next request is taken
// in the cycle the result first shows, or later still while an earlier result
// waits at the output. No result comes from other requests. Sums read as zero
// after reset and after each classification.
// Templates read before they are written give undefined results.
`include "assert_macros.svh"
module knn_template_classifier (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    knn_in_if.sink    i_req,
    knn_out_if.source o_res
);
    import knn_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_ACC   = 6'b000010,
        ST_SORT  = 6'b000100,
        ST_DRAIN = 6'b001000,
        ST_VOTE  = 6'b010000,
        ST_OUT   = 6'b100000
    } t_state;

    t_state r_state;
    t_in_req r_req;
    logic [TIDX_W:0] r_cnt;
    logic [TIDX_W:0] r_rd_cnt;

    // memories
    logic [SAMPLE_W-1:0] r_store [TEMPLATE_COUNT*GATE_COUNT];
    logic [CLASS_W-1:0]  r_labels [TEMPLATE_COUNT];
    logic [SUM_W-1:0]    r_sums [TEMPLATE_COUNT];
    logic [SAMPLE_W-1:0] r_tpl_q;
    logic [SUM_W-1:0]    r_sum_q;
    logic [CLASS_W-1:0]  r_lab_q;
    logic                r_rd_valid;
    logic [TIDX_W-1:0]   r_rd_idx;
    logic                r_sum_zero;

    logic [SAMPLE_W-1:0] sat_in;
    assign sat_in = (i_req.data.sample_value > SAMPLE_ONE) ? SAMPLE_ONE
                                                          : i_req.data.sample_value;

    // Request with its sample already clamped to 1.0
    t_in_req req_sat;
    always_comb begin
        req_sat              = i_req.data;
        req_sat.sample_value = sat_in;
    end

    logic accept;
    assign accept = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == ST_IDLE);

    logic gate_ok;
    assign gate_ok = ({1'b0, r_req.gate_index} < (GIDX_W+1)'(GATE_COUNT));

    // Read side: one template per cycle
    logic [TIDX_W-1:0] rd_idx;
    assign rd_idx = r_rd_cnt[TIDX_W-1:0];
    logic rd_en;
    assign rd_en = ((r_state == ST_ACC) || (r_state == ST_SORT))
                   && (r_rd_cnt < (TIDX_W+1)'(TEMPLATE_COUNT));

    always_ff @(posedge i_clk) begin
        r_tpl_q <= r_store[{rd_idx, r_req.gate_index[GIDX_W-1:0]}];
        r_sum_q <= r_sums[rd_idx];
        r_lab_q <= r_labels[rd_idx];
        r_rd_idx <= rd_idx;
    end

    // Treat the stored sums as zero until a query has written them
    logic [SUM_W-1:0] sum_rd;
    assign sum_rd = r_sum_zero ? '0 : r_sum_q;

    // Squared difference and saturating add for the template just read
    logic [SAMPLE_W-1:0] mag;
    logic [2*SAMPLE_W-1:0] sq;
    logic [SUM_W:0] acc;
    logic [SUM_W-1:0] acc_sat;
    assign mag = (r_req.sample_value >= r_tpl_q) ? r_req.sample_value - r_tpl_q
                                                 : r_tpl_q - r_req.sample_value;
    assign sq = mag * mag;
    assign acc = {1'b0, sum_rd} + {{(SUM_W+1-2*SAMPLE_W){1'b0}}, sq};
    assign acc_sat = acc[SUM_W] ? SUM_MAX : acc[SUM_W-1:0];

    // Write side: loads, sum updates, clear during sorting
    always_ff @(posedge i_clk) begin
        if (accept && i_req.data.req_type == REQ_LOAD
            && {1'b0, i_req.data.gate_index} < (GIDX_W+1)'(GATE_COUNT)
            && {1'b0, i_req.data.template_index} < (TIDX_W+1)'(TEMPLATE_COUNT)) begin
            r_store[{i_req.data.template_index[TIDX_W-1:0],
                     i_req.data.gate_index[GIDX_W-1:0]}] <= sat_in;
            r_labels[i_req.data.template_index[TIDX_W-1:0]] <= i_req.data.class_label;
        end else if (r_rd_valid && r_state == ST_ACC && gate_ok) begin
            r_sums[r_rd_idx] <= acc_sat;
        end else if (r_rd_valid && r_state == ST_SORT) begin
            r_sums[r_rd_idx] <= '0;
        end
    end

    // Sorting chain
    logic   c_valid [PICKS+1];
    t_token c_tok [PICKS+1];
    logic   h_valid [PICKS];
    t_token h_tok [PICKS];
    logic   chain_clear, chain_shift;

    assign c_valid[0] = r_rd_valid && (r_state == ST_SORT);
    assign c_tok[0]   = '{idx: r_rd_idx, sum: sum_rd, label: r_lab_q};
    assign chain_clear = (r_state == ST_IDLE);
    assign chain_shift = (r_state == ST_SORT) || (r_state == ST_DRAIN);

    for (genvar g = 0; g < PICKS; g++) begin : g_cell
        knn_cell u_cell (
            .i_clk       (i_clk),
            .i_clear     (chain_clear),
            .i_shift     (chain_shift),
            .i_valid     (c_valid[g]),
            .i_tok       (c_tok[g]),
            .o_valid     (c_valid[g+1]),
            .o_tok       (c_tok[g+1]),
            .o_held_valid(h_valid[g]),
            .o_held      (h_tok[g])
        );
    end

    // Vote count for one class per cycle
    logic [CLASS_W-1:0] r_best_class;
    logic [VOTE_W-1:0]  r_best_votes;
    logic [VOTE_W-1:0]  cls_votes;
    always_comb begin
        cls_votes = '0;
        for (int i = 0; i < PICKS; i++) begin
            if (h_valid[i] && h_tok[i].label == r_cnt[CLASS_W-1:0])
                cls_votes = cls_votes + VOTE_W'(1);
        end
    end

    t_out_req r_out;
    logic     r_out_valid;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt        <= '0;
            r_rd_cnt     <= '0;
            r_rd_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_sum_zero   <= 1'b1;
            r_best_class <= '0;
            r_best_votes <= '0;
        end else begin
            r_rd_valid <= rd_en;
            if (o_res.valid && o_res.ready) r_out_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    r_rd_cnt <= '0;
                    r_cnt    <= '0;
                    if (accept) begin
                        r_req <= req_sat;
                        if (i_req.data.req_type == REQ_QUERY) r_state <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    if (rd_en) r_rd_cnt <= r_rd_cnt + (TIDX_W+1)'(1);
                    else if (!r_rd_valid) begin
                        // Sums now hold real data unless nothing was added
                        if (gate_ok) r_sum_zero <= 1'b0;
                        r_rd_cnt <= '0;
                        r_state  <= r_req.last_gate ? ST_SORT : ST_IDLE;
                    end
                end
                ST_SORT: begin
                    if (rd_en) r_rd_cnt <= r_rd_cnt + (TIDX_W+1)'(1);
                    else if (!r_rd_valid) begin
                        r_cnt   <= '0;
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (r_cnt == (TIDX_W+1)'(PICKS)) begin
                        r_cnt        <= '0;
                        r_best_class <= '0;
                        r_best_votes <= '0;
                        r_state      <= ST_VOTE;
                    end else r_cnt <= r_cnt + (TIDX_W+1)'(1);
                end
                ST_VOTE: begin
                    if (cls_votes > r_best_votes) begin
                        r_best_votes <= cls_votes;
                        r_best_class <= r_cnt[CLASS_W-1:0];
                    end
                    if (r_cnt == (TIDX_W+1)'(CLASS_COUNT - 1)) r_state <= ST_OUT;
                    r_cnt <= r_cnt + (TIDX_W+1)'(1);
                end
                ST_OUT: begin
                    if (!r_out_valid) begin
                        r_out       <= '{winner_class: r_best_class,
                                         vote_count: r_best_votes};
                        r_out_valid <= 1'b1;
                        r_sum_zero  <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    `ASSERT_IMPL(a_onehot, i_clk, i_rst_n, $onehot(r_state))
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_res.valid && !o_res.ready, o_res.valid && $stable(o_res.data))
    `ASSERT_IMPL(a_votes_le, i_clk, i_rst_n, r_best_votes <= VOTE_W'(PICKS))
    `ASSERT_NEXT(a_post_idle, i_clk, i_rst_n, r_state == ST_OUT && !r_out_valid, r_state == ST_IDLE && o_res.valid)
endmodule
`default_nettype wire
